@@ rtl/bmd_pkg.sv @@
// shared constants and types for the bisquare mean deviance block
package bmd_pkg;

    // default number of fraction bits of all fixed point values
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int DATA_W   = 32;
    localparam int RADIUS_W = 31;

    // one classified sample as it waits between front and back
    typedef struct packed {
        logic                in_cut;
        logic [RADIUS_W-1:0] abs_res;
        logic [DATA_W-1:0]   weight;
        logic                last;
    } sample_t;

endpackage

@@ rtl/bmd_front.sv @@
// front end: radius register, residual, cutoff test and a two-entry sample queue
module bmd_front #(
    parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bmd_pkg::RADIUS_W-1:0]        cfg_wdata,
    output logic [bmd_pkg::RADIUS_W-1:0]        radius,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bmd_pkg::DATA_W-1:0]   target,
    input  logic signed [bmd_pkg::DATA_W-1:0]   offset,
    input  logic signed [bmd_pkg::DATA_W-1:0]   prediction,
    input  logic [bmd_pkg::DATA_W-1:0]          weight,
    input  logic                                last,
    input  logic                                pop,
    output logic                                q_valid,
    output bmd_pkg::sample_t                    q_data
);

    localparam int RW = bmd_pkg::RADIUS_W;

    logic [RW-1:0]       radius_reg;
    logic signed [33:0]  res;
    logic [33:0]         abs_res;
    logic                push;
    bmd_pkg::sample_t    entry;
    bmd_pkg::sample_t    q_mem [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;

    // cutoff radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RW'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    assign radius = radius_reg;

    // residual and its magnitude
    always_comb
    begin
        res     = 34'(target) - 34'(offset) - 34'(prediction);
        abs_res = res[33] ? 34'(-res) : 34'(res);
    end

    // classify the incoming request
    always_comb
    begin
        entry.in_cut  = abs_res < {3'b000, radius_reg};
        entry.abs_res = abs_res[RW-1:0];
        entry.weight  = weight;
        entry.last    = last;
    end

    assign in_ready = count_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_data   = q_mem[rd_ptr_reg];

    // sample queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/bmd_back.sv @@
// back end: per-sample loss sequencer, saturating sums and the mean divider
module bmd_back #(
    parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bmd_pkg::RADIUS_W-1:0]  radius,
    input  logic                          q_valid,
    input  bmd_pkg::sample_t              q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmd_pkg::DATA_W-1:0]    mean_loss,
    output logic                          zero_weight
);

    localparam int F       = FRAC_BITS;
    localparam int RW      = bmd_pkg::RADIUS_W;
    localparam int RR_W    = 2 * RW - F;
    localparam int CSTEPS  = (RR_W + 7) / 8;
    localparam int RR_PAD  = CSTEPS * 8;
    localparam int CHI_W   = RR_W - 32;
    localparam int PLO_W   = 32 + F + 1;
    localparam int PHI_W   = CHI_W + F + 1;
    localparam int CG_W    = RR_W + F + 1;
    localparam int FULL_W  = RR_W + 33;
    localparam int CNT_W   = $clog2(F);
    localparam int NUM_W   = 64 + F;
    localparam int MCNT_W  = $clog2(NUM_W);
    localparam logic [F:0]        ONE      = (F+1)'(1) << F;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(F - 1);
    localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(NUM_W - 1);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_LOAD = 13'b0000000000010,
        ST_DIV  = 13'b0000000000100,
        ST_SQ   = 13'b0000000001000,
        ST_S2   = 13'b0000000010000,
        ST_S3   = 13'b0000000100000,
        ST_M1   = 13'b0000001000000,
        ST_M2   = 13'b0000010000000,
        ST_W1   = 13'b0000100000000,
        ST_W2   = 13'b0001000000000,
        ST_ACC  = 13'b0010000000000,
        ST_MEAN = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    bmd_pkg::sample_t    item_reg, item_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RR_PAD-1:0]   rr_sh_reg, rr_sh_next;
    logic [RR_PAD-1:0]   c_reg, c_next;
    logic [2:0]          rem6_reg, rem6_next;
    logic [RW-1:0]       rema_reg, rema_next;
    logic [F-1:0]        a_reg, a_next;
    logic [F:0]          s_reg, s_next;
    logic [F:0]          s2_reg, s2_next;
    logic [F:0]          g_reg, g_next;
    logic [PLO_W-1:0]    plo_reg, plo_next;
    logic [RR_W-1:0]     m_reg, m_next;
    logic [63:0]         wlo_reg, wlo_next;
    logic [63:0]         loss_reg, loss_next;
    logic [63:0]         loss_sum_reg, loss_sum_next;
    logic [63:0]         wsum_reg, wsum_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [63:0]         mrem_reg, mrem_next;
    logic [31:0]         q_reg, q_next;
    logic                sat_reg, sat_next;
    logic [MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         mean_reg, mean_next;
    logic                zero_weight_reg, zero_weight_next;

    logic [61:0]         rr_prod;
    logic [3:0]          d6;
    logic [2:0]          r6;
    logic [7:0]          qb6;
    logic [RW:0]         arem2;
    logic                age;
    logic [2*F-1:0]      aa;
    logic [2*F+1:0]      ss;
    logic [PHI_W-1:0]    phi;
    logic [CG_W-1:0]     cg;
    logic [RR_W-1:0]     whi;
    logic [FULL_W-1:0]   wfull;
    logic [FULL_W-1:0]   wsh;
    logic [64:0]         lsum;
    logic [64:0]         wsum;
    logic [64:0]         mrem2;
    logic                mge;

    // squared radius, then one multiply per arithmetic state
    always_comb
    begin
        rr_prod = 62'(radius) * 62'(radius);
        aa      = a_reg * a_reg;
        ss      = (2*F+2)'(s_reg) * (2*F+2)'((state_reg == ST_S3) ? s2_reg : s_reg);
        phi     = PHI_W'(c_reg[RR_W-1:32]) * PHI_W'(g_reg);
        cg      = CG_W'(plo_reg) + (CG_W'(phi) << 32);
        whi     = RR_W'(item_reg.weight) * RR_W'(m_reg[RR_W-1:32]);
        wfull   = FULL_W'(wlo_reg) + (FULL_W'(whi) << 32);
        wsh     = wfull >> F;
        lsum    = 65'(loss_sum_reg) + 65'(loss_reg);
        wsum    = 65'(wsum_reg) + 65'(item_reg.weight);
    end

    // divide the squared radius by six, eight bits per cycle
    always_comb
    begin
        r6  = rem6_reg;
        qb6 = '0;
        for (int k = 0; k < 8; k++)
        begin
            d6 = {r6, rr_sh_reg[RR_PAD-1-k]};
            if (d6 >= 4'd6)
            begin
                d6 = d6 - 4'd6;
                qb6[7-k] = 1'b1;
            end
            r6 = d6[2:0];
        end
    end

    // one restoring step of the residual to radius ratio
    always_comb
    begin
        arem2 = {rema_reg, 1'b0};
        age   = arem2 >= {1'b0, radius};
    end

    // one restoring step of the mean divider
    always_comb
    begin
        mrem2 = {mrem_reg, num_reg[NUM_W-1]};
        mge   = mrem2 >= {1'b0, wsum_reg};
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        cnt_next         = cnt_reg;
        rr_sh_next       = rr_sh_reg;
        c_next           = c_reg;
        rem6_next        = rem6_reg;
        rema_next        = rema_reg;
        a_next           = a_reg;
        s_next           = s_reg;
        s2_next          = s2_reg;
        g_next           = g_reg;
        plo_next         = plo_reg;
        m_next           = m_reg;
        wlo_next         = wlo_reg;
        loss_next        = loss_reg;
        loss_sum_next    = loss_sum_reg;
        wsum_next        = wsum_reg;
        num_next         = num_reg;
        mrem_next        = mrem_reg;
        q_next           = q_reg;
        sat_next         = sat_reg;
        mcnt_next        = mcnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        mean_next        = mean_reg;
        zero_weight_next = zero_weight_reg;
        pop              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    item_next  = q_data;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                rr_sh_next = RR_PAD'(rr_prod >> F);
                c_next     = '0;
                rem6_next  = 3'd0;
                rema_next  = item_reg.in_cut ? item_reg.abs_res : '0;
                a_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rema_next = age ? RW'(arem2 - {1'b0, radius}) : arem2[RW-1:0];
                a_next    = {a_reg[F-2:0], age};
                if (32'(cnt_reg) < CSTEPS)
                begin
                    rem6_next  = r6;
                    rr_sh_next = rr_sh_reg << 8;
                    c_next     = {c_reg[RR_PAD-9:0], qb6};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                s_next     = ONE - {1'b0, aa[2*F-1:F]};
                state_next = ST_S2;
            end
            ST_S2:
            begin
                s2_next    = ss[2*F:F];
                state_next = ST_S3;
            end
            ST_S3:
            begin
                g_next     = item_reg.in_cut ? ONE - ss[2*F:F] : ONE;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                plo_next   = PLO_W'(c_reg[31:0]) * PLO_W'(g_reg);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                m_next     = cg[F +: RR_W];
                state_next = ST_W1;
            end
            ST_W1:
            begin
                wlo_next   = 64'(item_reg.weight) * 64'(m_reg[31:0]);
                state_next = ST_W2;
            end
            ST_W2:
            begin
                loss_next  = (|wsh[FULL_W-1:64]) ? '1 : wsh[63:0];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                loss_sum_next = lsum[64] ? '1 : lsum[63:0];
                wsum_next     = wsum[64] ? '1 : wsum[63:0];
                num_next      = {loss_sum_next, F'(0)};
                mrem_next     = '0;
                q_next        = '0;
                sat_next      = 1'b0;
                mcnt_next     = '0;
                state_next    = item_reg.last ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN:
            begin
                mrem_next = mge ? 64'(mrem2 - {1'b0, wsum_reg}) : mrem2[63:0];
                num_next  = num_reg << 1;
                sat_next  = sat_reg || q_reg[31];
                q_next    = {q_reg[30:0], mge};
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == MCNT_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    zero_weight_next = wsum_reg == '0;
                    mean_next        = (sat_reg || wsum_reg == '0) ? '1 : q_reg;
                    loss_sum_next    = '0;
                    wsum_next        = '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            cnt_reg         <= '0;
            rr_sh_reg       <= '0;
            c_reg           <= '0;
            rem6_reg        <= '0;
            rema_reg        <= '0;
            a_reg           <= '0;
            s_reg           <= '0;
            s2_reg          <= '0;
            g_reg           <= '0;
            plo_reg         <= '0;
            m_reg           <= '0;
            wlo_reg         <= '0;
            loss_reg        <= '0;
            loss_sum_reg    <= '0;
            wsum_reg        <= '0;
            num_reg         <= '0;
            mrem_reg        <= '0;
            q_reg           <= '0;
            sat_reg         <= 1'b0;
            mcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            mean_reg        <= '0;
            zero_weight_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            cnt_reg         <= cnt_next;
            rr_sh_reg       <= rr_sh_next;
            c_reg           <= c_next;
            rem6_reg        <= rem6_next;
            rema_reg        <= rema_next;
            a_reg           <= a_next;
            s_reg           <= s_next;
            s2_reg          <= s2_next;
            g_reg           <= g_next;
            plo_reg         <= plo_next;
            m_reg           <= m_next;
            wlo_reg         <= wlo_next;
            loss_reg        <= loss_next;
            loss_sum_reg    <= loss_sum_next;
            wsum_reg        <= wsum_next;
            num_reg         <= num_next;
            mrem_reg        <= mrem_next;
            q_reg           <= q_next;
            sat_reg         <= sat_next;
            mcnt_reg        <= mcnt_next;
            out_valid_reg   <= out_valid_next;
            mean_reg        <= mean_next;
            zero_weight_reg <= zero_weight_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mean_loss   = mean_reg;
    assign zero_weight = zero_weight_reg;

`ifndef SYNTHESIS
    // a zero total weight always comes with a saturated mean
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && zero_weight_reg |-> mean_reg == '1)
        else $error("zero weight result without saturated mean");

    // a sample taken from the queue starts the sequence
    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_LOAD)
        else $error("popped sample did not start processing");

    // sums are cleared once a result has been loaded
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && (!out_valid_reg || out_ready)
        |=> loss_sum_reg == '0 && wsum_reg == '0 && out_valid_reg)
        else $error("sums not cleared after result");
`endif

endmodule

@@ rtl/bisquare_mean_deviance.sv @@
// top level of the weighted mean bisquare loss block
//
//  channel   direction  handshake            payload
//  config    in         cfg_we               cfg_wdata (radius)
//  sample    in         in_valid/in_ready    target, offset, prediction, weight, last
//  result    out        out_valid/out_ready  mean_loss, zero_weight
//
// each sample request passes through the back end sequencer: the bit-per-cycle
// ratio divider and then the chain of narrow multiplies
// a sample marked last then also runs the mean divider
// a two-entry queue lets the front take requests while the back end works
// reset is asynchronous and active low; radius resets to 1.0
// a stalled result holds the back end in its output state only
module bisquare_mean_deviance #(
    parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bmd_pkg::RADIUS_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [bmd_pkg::DATA_W-1:0]  target,
    input  logic signed [bmd_pkg::DATA_W-1:0]  offset,
    input  logic signed [bmd_pkg::DATA_W-1:0]  prediction,
    input  logic [bmd_pkg::DATA_W-1:0]         weight,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bmd_pkg::DATA_W-1:0]         mean_loss,
    output logic                               zero_weight
);

    logic [bmd_pkg::RADIUS_W-1:0] radius;
    logic                         pop;
    logic                         q_valid;
    bmd_pkg::sample_t             q_data;

    // classify and queue samples
    bmd_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .radius     (radius),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .target     (target),
        .offset     (offset),
        .prediction (prediction),
        .weight     (weight),
        .last       (last),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_data     (q_data)
    );

    // loss, sums and mean
    bmd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .radius      (radius),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_loss   (mean_loss),
        .zero_weight (zero_weight)
    );

endmodule
